>>> src/wsdf_pkg.sv
// Shared constants for the WebSocket frame deframer: parse phases, header fields, widths.
package wsdf_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned OPCODE_W   = 4;
   localparam int unsigned PHASE_W    = 3;
   localparam int unsigned EXT_CNT_W  = 4;
   localparam int unsigned KEY_CNT_W  = 3;
   localparam int unsigned KEY_W      = 32;
   localparam int unsigned LEN_W      = 64;
   localparam int unsigned POS_W      = 2;

   // Parse phase codes; the unused codes behave like PH_HDR0.
   localparam logic [PHASE_W-1:0] PH_HDR0 = 3'd0;
   localparam logic [PHASE_W-1:0] PH_HDR1 = 3'd1;
   localparam logic [PHASE_W-1:0] PH_EXT  = 3'd2;
   localparam logic [PHASE_W-1:0] PH_KEY  = 3'd3;
   localparam logic [PHASE_W-1:0] PH_DATA = 3'd4;

   // Short length codes that announce an extended length field.
   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   // Number of extended length bytes and mask key bytes.
   localparam logic [EXT_CNT_W-1:0] EXT16_BYTES = 4'd2;
   localparam logic [EXT_CNT_W-1:0] EXT64_BYTES = 4'd8;
   localparam logic [KEY_CNT_W-1:0] KEY_BYTES   = 3'd4;

endpackage

>>> src/websocket_frame_deframer.sv
// WebSocket frame deframer: header parse, payload unmasking and registered result stage.
// Results reach the rsp_ channel from a register; one stream byte per cycle is accepted
//   unless a stalled result holds req_ready low. The header state update and the 64-bit
//   payload count decrement with its zero test fit between the state and result registers.
// Header bytes produce no result, except the byte that ends a zero-length frame's header.
// Reset (synchronous, active high) returns the parser to the first header byte and clears
//   all parse state and the result valid flag; result payload registers are not reset.
module websocket_frame_deframer (
   input  logic                                clock,
   input  logic                                reset,
   // Input stream, one byte per transaction
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [wsdf_pkg::BYTE_W-1:0]         req_stream_byte,
   // Result channel, one payload byte or empty-frame marker per transaction
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [wsdf_pkg::BYTE_W-1:0]         rsp_payload_byte,
   output logic [wsdf_pkg::OPCODE_W-1:0]       rsp_frame_opcode,
   output logic                                rsp_frame_was_masked,
   output logic                                rsp_last_of_frame,
   output logic                                rsp_empty_frame
);

   // ------------------------------------------------------------------
   // Parse state
   // ------------------------------------------------------------------
   logic [wsdf_pkg::PHASE_W-1:0]   phase_ff,     phase_in;
   logic [wsdf_pkg::OPCODE_W-1:0]  opcode_ff,    opcode_in;
   logic                           masked_ff,    masked_in;
   logic [wsdf_pkg::EXT_CNT_W-1:0] ext_left_ff,  ext_left_in;
   logic [wsdf_pkg::KEY_W-1:0]     key_ff,       key_in;
   logic [wsdf_pkg::KEY_CNT_W-1:0] key_left_ff,  key_left_in;
   logic [wsdf_pkg::LEN_W-1:0]     remain_ff,    remain_in;
   logic [wsdf_pkg::POS_W-1:0]     pos_ff,       pos_in;

   // Result register
   logic                           rsp_valid_ff;
   logic [wsdf_pkg::BYTE_W-1:0]    rsp_byte_ff;
   logic [wsdf_pkg::OPCODE_W-1:0]  rsp_opcode_ff;
   logic                           rsp_masked_ff;
   logic                           rsp_last_ff;
   logic                           rsp_empty_ff;

   // Per-byte decode
   logic                           req_fire;
   logic                           emit;
   logic [wsdf_pkg::BYTE_W-1:0]    out_byte;
   logic                           out_last;
   logic                           out_empty;
   logic                           len_done;
   logic                           hdr_done;
   logic [wsdf_pkg::BYTE_W-1:0]    key_byte;

   // Take a new byte whenever the result register is empty or is being drained,
   // so a waiting result never stalls the stream by more than the consumer does.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // Key byte for the current payload position; position 0 uses the first key byte (MSBs).
   assign key_byte = key_ff[{~pos_ff, 3'b000} +: wsdf_pkg::BYTE_W];

   always_comb begin
      phase_in    = phase_ff;
      opcode_in   = opcode_ff;
      masked_in   = masked_ff;
      ext_left_in = ext_left_ff;
      key_in      = key_ff;
      key_left_in = key_left_ff;
      remain_in   = remain_ff;
      pos_in      = pos_ff;
      emit        = 1'b0;
      out_byte    = '0;
      out_last    = 1'b0;
      out_empty   = 1'b0;
      len_done    = 1'b0;
      hdr_done    = 1'b0;

      unique case (phase_ff)
         wsdf_pkg::PH_HDR1: begin
            // Mask flag and 7-bit length
            masked_in = req_stream_byte[7];
            key_in    = '0;
            pos_in    = '0;
            if (req_stream_byte[6:0] == wsdf_pkg::LEN_EXT16 ||
                req_stream_byte[6:0] == wsdf_pkg::LEN_EXT64) begin
               ext_left_in = (req_stream_byte[6:0] == wsdf_pkg::LEN_EXT16) ?
                             wsdf_pkg::EXT16_BYTES : wsdf_pkg::EXT64_BYTES;
               remain_in   = '0;
               phase_in    = wsdf_pkg::PH_EXT;
            end else begin
               remain_in = {{(wsdf_pkg::LEN_W-7){1'b0}}, req_stream_byte[6:0]};
               len_done  = 1'b1;
            end
         end
         wsdf_pkg::PH_EXT: begin
            // Shift in the big-endian extended length
            remain_in   = {remain_ff[wsdf_pkg::LEN_W-wsdf_pkg::BYTE_W-1:0], req_stream_byte};
            ext_left_in = (ext_left_ff != '0) ? ext_left_ff - 1'b1 : ext_left_ff;
            if (ext_left_in == '0) begin
               len_done = 1'b1;
            end
         end
         wsdf_pkg::PH_KEY: begin
            key_in      = {key_ff[wsdf_pkg::KEY_W-wsdf_pkg::BYTE_W-1:0], req_stream_byte};
            key_left_in = (key_left_ff != '0) ? key_left_ff - 1'b1 : key_left_ff;
            if (key_left_in == '0) begin
               hdr_done = 1'b1;
            end
         end
         wsdf_pkg::PH_DATA: begin
            // Unmask one payload byte and count it off
            pos_in    = pos_ff + 1'b1;
            remain_in = (remain_ff != '0) ? remain_ff - 1'b1 : remain_ff;
            out_last  = (remain_in == '0);
            if (out_last) begin
               phase_in = wsdf_pkg::PH_HDR0;
            end
            emit     = 1'b1;
            out_byte = req_stream_byte ^ key_byte;
         end
         default: begin
            // First header byte: hold the opcode nibble, ignore FIN and RSV
            opcode_in = req_stream_byte[wsdf_pkg::OPCODE_W-1:0];
            phase_in  = wsdf_pkg::PH_HDR1;
         end
      endcase

      // Length known: read the key next, or finish the header now
      if (len_done) begin
         if (masked_in) begin
            key_left_in = wsdf_pkg::KEY_BYTES;
            phase_in    = wsdf_pkg::PH_KEY;
         end else begin
            hdr_done = 1'b1;
         end
      end

      // Header complete: start the payload or emit the empty-frame marker
      if (hdr_done) begin
         pos_in = '0;
         if (remain_in == '0) begin
            phase_in  = wsdf_pkg::PH_HDR0;
            emit      = 1'b1;
            out_byte  = '0;
            out_last  = 1'b1;
            out_empty = 1'b1;
         end else begin
            phase_in = wsdf_pkg::PH_DATA;
         end
      end
   end

   // Advance parse state only on an accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= wsdf_pkg::PH_HDR0;
         opcode_ff   <= '0;
         masked_ff   <= 1'b0;
         ext_left_ff <= '0;
         key_ff      <= '0;
         key_left_ff <= '0;
         remain_ff   <= '0;
         pos_ff      <= '0;
      end else if (req_fire) begin
         phase_ff    <= phase_in;
         opcode_ff   <= opcode_in;
         masked_ff   <= masked_in;
         ext_left_ff <= ext_left_in;
         key_ff      <= key_in;
         key_left_ff <= key_left_in;
         remain_ff   <= remain_in;
         pos_ff      <= pos_in;
      end
   end

   // Result register: load on a producing transaction, drop when drained
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= emit;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && emit) begin
         rsp_byte_ff   <= out_byte;
         rsp_opcode_ff <= opcode_in;
         rsp_masked_ff <= masked_in;
         rsp_last_ff   <= out_last;
         rsp_empty_ff  <= out_empty;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_payload_byte     = rsp_byte_ff;
   assign rsp_frame_opcode     = rsp_opcode_ff;
   assign rsp_frame_was_masked = rsp_masked_ff;
   assign rsp_last_of_frame    = rsp_last_ff;
   assign rsp_empty_frame      = rsp_empty_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_frame) |-> (rsp_last_of_frame && rsp_payload_byte == '0))
      else $error("empty-frame marker without last flag or with data");

   a_data_has_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == wsdf_pkg::PH_DATA) |-> (remain_ff != '0))
      else $error("payload phase with zero remaining count");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> ($stable(phase_ff) && $stable(remain_ff)))
      else $error("parse state moved without an accepted byte");

   a_stall_holds_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload_byte)))
      else $error("stalled result changed");

endmodule
